// ===== sv/gass_pkg.sv =====
// ============================================================================
// gass_pkg - shared types and constants for the grid A* search step block
// Holds the opcode, status and phase codes, the per-cell memory word, the
// move table and the saturating cost helper.
// ============================================================================
package gass_pkg;

    localparam int GRID_SIDE_DEF = 16;
    localparam int COST_W        = 20;
    localparam int STAMP_W       = 16;
    localparam int DIR_W         = 4;

    localparam logic [COST_W-1:0] COST_MAX      = '1;
    localparam logic [COST_W-1:0] STRAIGHT_COST = COST_W'(1000);
    localparam logic [COST_W-1:0] DIAG_COST     = COST_W'(1414);

    typedef enum logic [1:0] {
        OP_NEW    = 2'd0,
        OP_EXPAND = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_SEARCHING = 3'd0,
        ST_GOAL      = 3'd1,
        ST_NO_PATH   = 3'd2,
        ST_PATH_CELL = 3'd3,
        ST_PATH_END  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SEARCH = 3'd1,
        PH_FOUND  = 3'd2,
        PH_NOPATH = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        MK_FREE   = 2'd0,
        MK_OPEN   = 2'd1,
        MK_CLOSED = 2'd2,
        MK_SPARE  = 2'd3
    } mark_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_INIT,
        S_EXP,
        S_SCAN,
        S_SCAN_END,
        S_CLOSE,
        S_NB_RD,
        S_NB_WR,
        S_PATH_RD,
        S_PATH_WR,
        S_RESULT
    } state_t;

    // One entry of the per-cell store.
    typedef struct packed {
        mark_t                mark;
        logic [COST_W-1:0]    cost;
        logic [DIR_W-1:0]     dir;
        logic [STAMP_W-1:0]   stamp;
    } cell_t;

    // Direction of one move: x up, x down, z up, z down.
    typedef struct packed {
        logic xp;
        logic xn;
        logic zp;
        logic zn;
    } move_t;

    // Move order: +x, -x, +z, -z, (+x,+z), (+x,-z), (-x,-z), (-x,+z).
    function automatic move_t move_of(input logic [2:0] d);
        move_t m;
        m = '0;
        case (d)
            3'd0: m = '{xp: 1'b1, xn: 1'b0, zp: 1'b0, zn: 1'b0};
            3'd1: m = '{xp: 1'b0, xn: 1'b1, zp: 1'b0, zn: 1'b0};
            3'd2: m = '{xp: 1'b0, xn: 1'b0, zp: 1'b1, zn: 1'b0};
            3'd3: m = '{xp: 1'b0, xn: 1'b0, zp: 1'b0, zn: 1'b1};
            3'd4: m = '{xp: 1'b1, xn: 1'b0, zp: 1'b1, zn: 1'b0};
            3'd5: m = '{xp: 1'b1, xn: 1'b0, zp: 1'b0, zn: 1'b1};
            3'd6: m = '{xp: 1'b0, xn: 1'b1, zp: 1'b0, zn: 1'b1};
            3'd7: m = '{xp: 1'b0, xn: 1'b1, zp: 1'b1, zn: 1'b0};
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

endpackage

// ===== sv/gass_ram.sv =====
// ============================================================================
// gass_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module gass_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/grid_astar_search_step_top.sv =====
// ============================================================================
// grid_astar_search_step_top - A* search step engine on an open square grid
// Eight-neighbour A* with costs in thousandths, Manhattan heuristic, and
// read-out of the found path from the goal back to the start.
// ============================================================================
//
//  channel | direction | handshake          | word fields
//  --------+-----------+--------------------+-----------------------------------
//  s_      | in        | s_valid / s_ready  | opcode, start_x/z, goal_x/z
//  m_      | out       | m_valid / m_ready  | status, path_x/z, last
//
// An expansion scans every cell through the single read port of the cell
// memory, then visits the eight neighbours, each by a read state and a write
// state; a neighbour off the grid skips the write state.
// A new search first clears the cell memory, one entry per cycle, before it
// opens the start cell. A path read goes through a read state and a write
// state, or straight to the result when the cursor already sits on the start cell.
// Reset (aresetn low, synchronous) returns the controller to idle with no
// search; the cell memory is only read after a new search has cleared it.
// One word is worked on at a time; the result waits in the output register
// while the next input word is already accepted.
//
module grid_astar_search_step_top #(
    parameter int GRID_SIDE = gass_pkg::GRID_SIDE_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [3:0] s_start_x,
    input  logic [3:0] s_start_z,
    input  logic [3:0] s_goal_x,
    input  logic [3:0] s_goal_z,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [3:0] m_path_x,
    output logic [3:0] m_path_z,
    output logic       m_last
);

    localparam int NCELLS = GRID_SIDE * GRID_SIDE;
    localparam int CW     = $clog2(GRID_SIDE);
    localparam int IW     = $clog2(NCELLS);
    localparam int CELL_BITS = $bits(gass_pkg::cell_t);

    localparam logic [CW-1:0] X_MAX   = CW'(GRID_SIDE - 1);
    localparam logic [IW-1:0] IDX_MAX = IW'(NCELLS - 1);

    // F = G + Manhattan distance to the goal times 1000, saturated.
    function automatic logic [gass_pkg::COST_W-1:0] f_of(
        input logic [CW-1:0] x, input logic [CW-1:0] z,
        input logic [CW-1:0] gx, input logic [CW-1:0] gz,
        input logic [gass_pkg::COST_W-1:0] g);
        logic [CW-1:0] ddx;
        logic [CW-1:0] ddz;
        logic [CW:0]   d;
        logic [gass_pkg::COST_W-1:0] h;
        ddx = (x > gx) ? x - gx : gx - x;
        ddz = (z > gz) ? z - gz : gz - z;
        d   = {1'b0, ddx} + {1'b0, ddz};
        h   = gass_pkg::COST_W'(32'(d) * 1000);
        return gass_pkg::sat_add(g, h);
    endfunction

    function automatic logic [CW-1:0] clamp(input logic [3:0] v);
        return (32'(v) >= GRID_SIDE) ? X_MAX : CW'(v);
    endfunction

    function automatic logic [IW-1:0] index_of(input logic [CW-1:0] x,
                                               input logic [CW-1:0] z);
        return IW'(32'(z) * GRID_SIDE + 32'(x));
    endfunction

    gass_pkg::state_t state_reg, state_next;
    gass_pkg::phase_t phase_reg, phase_next;

    logic [CW-1:0] sx_reg, sx_next, sz_reg, sz_next;
    logic [CW-1:0] gx_reg, gx_next, gz_reg, gz_next;
    logic [CW-1:0] cx_reg, cx_next, cz_reg, cz_next;
    logic [gass_pkg::STAMP_W-1:0] stamp_reg, stamp_next;

    // Sweep counters for the clear pass and the scan.
    logic [CW-1:0] ix_reg, ix_next, iz_reg, iz_next;
    logic [IW-1:0] idx_reg, idx_next;

    // Scan read pipeline: coordinates of the entry whose data arrives now.
    logic          rv_reg, rv_next;
    logic [CW-1:0] rx_reg, rx_next, rz_reg, rz_next;
    logic [IW-1:0] ridx_reg, ridx_next;

    // Best open cell found so far.
    logic                          bv_reg, bv_next;
    logic [gass_pkg::COST_W-1:0]   bf_reg, bf_next, bg_reg, bg_next;
    logic [gass_pkg::STAMP_W-1:0]  bs_reg, bs_next;
    logic [IW-1:0]                 bidx_reg, bidx_next;
    logic [CW-1:0]                 bx_reg, bx_next, bz_reg, bz_next;
    logic [gass_pkg::DIR_W-1:0]    bd_reg, bd_next;

    // Neighbour walk.
    logic [2:0]    nd_reg, nd_next;
    logic [CW-1:0] nx_reg, nx_next, nz_reg, nz_next;
    logic [IW-1:0] nidx_reg, nidx_next;

    // Result waiting for the output register.
    gass_pkg::status_t res_status_reg, res_status_next;
    logic [3:0] res_px_reg, res_px_next, res_pz_reg, res_pz_next;
    logic       res_last_reg, res_last_next;

    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_status_reg, m_status_next;
    logic [3:0] m_px_reg, m_px_next, m_pz_reg, m_pz_next;
    logic       m_last_reg, m_last_next;

    // Cell memory port signals.
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr, ram_raddr;
    gass_pkg::cell_t       ram_wdata, ram_rdata;
    logic [CELL_BITS-1:0]  ram_rbits;

    // Neighbour geometry for the current direction.
    gass_pkg::move_t       nmv;
    logic                  n_off;
    logic [CW-1:0]         ncx, ncz;

    // Scan compare and neighbour update terms.
    logic [gass_pkg::COST_W-1:0] scan_f, g_new, f_new, f_old;
    logic                        scan_take;
    logic                        s_acc, out_free;

    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    gass_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (NCELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );
    assign ram_rdata = gass_pkg::cell_t'(ram_rbits);

    // Geometry of the neighbour in direction nd_reg around the best cell.
    always_comb begin
        nmv   = gass_pkg::move_of(nd_reg);
        n_off = (nmv.xp && bx_reg == X_MAX) || (nmv.xn && bx_reg == '0) ||
                (nmv.zp && bz_reg == X_MAX) || (nmv.zn && bz_reg == '0);
        ncx   = nmv.xp ? bx_reg + CW'(1) : (nmv.xn ? bx_reg - CW'(1) : bx_reg);
        ncz   = nmv.zp ? bz_reg + CW'(1) : (nmv.zn ? bz_reg - CW'(1) : bz_reg);
    end

    always_comb begin
        scan_f    = f_of(rx_reg, rz_reg, gx_reg, gz_reg, ram_rdata.cost);
        scan_take = rv_reg && (ram_rdata.mark == gass_pkg::MK_OPEN) &&
                    (!bv_reg || scan_f < bf_reg ||
                     (scan_f == bf_reg && ram_rdata.stamp < bs_reg));
        g_new     = gass_pkg::sat_add(bg_reg, nd_reg[2] ? gass_pkg::DIAG_COST
                                                        : gass_pkg::STRAIGHT_COST);
        f_new     = f_of(nx_reg, nz_reg, gx_reg, gz_reg, g_new);
        f_old     = f_of(nx_reg, nz_reg, gx_reg, gz_reg, ram_rdata.cost);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gass_pkg::S_IDLE: begin
                if (s_acc) begin
                    case (gass_pkg::opcode_t'(s_opcode))
                        gass_pkg::OP_NEW:    state_next = gass_pkg::S_CLEAR;
                        gass_pkg::OP_EXPAND: state_next = gass_pkg::S_EXP;
                        gass_pkg::OP_READ: begin
                            if (phase_reg == gass_pkg::PH_FOUND &&
                                !(cx_reg == sx_reg && cz_reg == sz_reg)) begin
                                state_next = gass_pkg::S_PATH_RD;
                            end else begin
                                state_next = gass_pkg::S_RESULT;
                            end
                        end
                        default: state_next = gass_pkg::S_RESULT;
                    endcase
                end
            end
            gass_pkg::S_CLEAR: begin
                if (idx_reg == IDX_MAX) begin
                    state_next = gass_pkg::S_INIT;
                end
            end
            gass_pkg::S_INIT: state_next = gass_pkg::S_EXP;
            gass_pkg::S_EXP: begin
                if (phase_reg == gass_pkg::PH_SEARCH) begin
                    state_next = gass_pkg::S_SCAN;
                end else begin
                    state_next = gass_pkg::S_RESULT;
                end
            end
            gass_pkg::S_SCAN: begin
                if (idx_reg == IDX_MAX) begin
                    state_next = gass_pkg::S_SCAN_END;
                end
            end
            gass_pkg::S_SCAN_END: state_next = gass_pkg::S_CLOSE;
            gass_pkg::S_CLOSE: begin
                if (!bv_reg || (bx_reg == gx_reg && bz_reg == gz_reg)) begin
                    state_next = gass_pkg::S_RESULT;
                end else begin
                    state_next = gass_pkg::S_NB_RD;
                end
            end
            gass_pkg::S_NB_RD: begin
                if (!n_off) begin
                    state_next = gass_pkg::S_NB_WR;
                end else if (nd_reg == 3'd7) begin
                    state_next = gass_pkg::S_RESULT;
                end
            end
            gass_pkg::S_NB_WR: begin
                if (nd_reg == 3'd7) begin
                    state_next = gass_pkg::S_RESULT;
                end else begin
                    state_next = gass_pkg::S_NB_RD;
                end
            end
            gass_pkg::S_PATH_RD: state_next = gass_pkg::S_PATH_WR;
            gass_pkg::S_PATH_WR: state_next = gass_pkg::S_RESULT;
            gass_pkg::S_RESULT: begin
                if (out_free) begin
                    state_next = gass_pkg::S_IDLE;
                end
            end
            default: state_next = gass_pkg::S_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '{mark: gass_pkg::MK_FREE, cost: '0, dir: '0, stamp: '0};
        ram_raddr = idx_reg;
        case (state_reg)
            gass_pkg::S_CLEAR: begin
                ram_we = 1'b1;
            end
            gass_pkg::S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = index_of(sx_reg, sz_reg);
                ram_wdata = '{mark: gass_pkg::MK_OPEN, cost: '0, dir: '0, stamp: '0};
            end
            gass_pkg::S_CLOSE: begin
                ram_we    = bv_reg;
                ram_waddr = bidx_reg;
                ram_wdata = '{mark: gass_pkg::MK_CLOSED, cost: bg_reg,
                              dir: bd_reg, stamp: bs_reg};
            end
            gass_pkg::S_NB_RD: begin
                ram_raddr = index_of(ncx, ncz);
            end
            gass_pkg::S_NB_WR: begin
                ram_waddr = nidx_reg;
                if (ram_rdata.mark == gass_pkg::MK_OPEN) begin
                    ram_we    = f_new < f_old;
                    ram_wdata = '{mark: gass_pkg::MK_OPEN, cost: g_new,
                                  dir: {1'b0, nd_reg}, stamp: ram_rdata.stamp};
                end else if (ram_rdata.mark != gass_pkg::MK_CLOSED) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{mark: gass_pkg::MK_OPEN, cost: g_new,
                                  dir: {1'b0, nd_reg}, stamp: stamp_reg};
                end
            end
            gass_pkg::S_PATH_RD: begin
                ram_raddr = index_of(cx_reg, cz_reg);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Datapath registers.
    always_comb begin
        gass_pkg::move_t pm;
        phase_next      = phase_reg;
        sx_next = sx_reg;  sz_next = sz_reg;
        gx_next = gx_reg;  gz_next = gz_reg;
        cx_next = cx_reg;  cz_next = cz_reg;
        stamp_next      = stamp_reg;
        ix_next = ix_reg;  iz_next = iz_reg;  idx_next = idx_reg;
        rv_next = 1'b0;    rx_next = ix_reg;  rz_next = iz_reg;  ridx_next = idx_reg;
        bv_next = bv_reg;  bf_next = bf_reg;  bg_next = bg_reg;  bs_next = bs_reg;
        bidx_next = bidx_reg;  bx_next = bx_reg;  bz_next = bz_reg;  bd_next = bd_reg;
        nd_next = nd_reg;  nx_next = nx_reg;  nz_next = nz_reg;  nidx_next = nidx_reg;
        res_status_next = res_status_reg;
        res_px_next     = res_px_reg;
        res_pz_next     = res_pz_reg;
        res_last_next   = res_last_reg;
        pm              = gass_pkg::move_of(ram_rdata.dir[2:0]);

        if (scan_take) begin
            bv_next   = 1'b1;
            bf_next   = scan_f;
            bg_next   = ram_rdata.cost;
            bs_next   = ram_rdata.stamp;
            bd_next   = ram_rdata.dir;
            bidx_next = ridx_reg;
            bx_next   = rx_reg;
            bz_next   = rz_reg;
        end

        case (state_reg)
            gass_pkg::S_IDLE: begin
                if (s_acc) begin
                    idx_next        = '0;
                    res_status_next = gass_pkg::ST_PATH_END;
                    res_px_next     = '0;
                    res_pz_next     = '0;
                    res_last_next   = 1'b0;
                    if (gass_pkg::opcode_t'(s_opcode) == gass_pkg::OP_NEW) begin
                        sx_next = clamp(s_start_x);
                        sz_next = clamp(s_start_z);
                        gx_next = clamp(s_goal_x);
                        gz_next = clamp(s_goal_z);
                    end else if (gass_pkg::opcode_t'(s_opcode) == gass_pkg::OP_READ &&
                                 phase_reg == gass_pkg::PH_FOUND &&
                                 cx_reg == sx_reg && cz_reg == sz_reg) begin
                        res_status_next = gass_pkg::ST_PATH_CELL;
                        res_px_next     = 4'(cx_reg);
                        res_pz_next     = 4'(cz_reg);
                        res_last_next   = 1'b1;
                        phase_next      = gass_pkg::PH_DONE;
                    end
                end
            end
            gass_pkg::S_CLEAR: begin
                idx_next = idx_reg + IW'(1);
            end
            gass_pkg::S_INIT: begin
                stamp_next = gass_pkg::STAMP_W'(1);
                phase_next = gass_pkg::PH_SEARCH;
            end
            gass_pkg::S_EXP: begin
                ix_next  = '0;
                iz_next  = '0;
                idx_next = '0;
                bv_next  = 1'b0;
                if (phase_reg == gass_pkg::PH_IDLE || phase_reg == gass_pkg::PH_NOPATH) begin
                    res_status_next = gass_pkg::ST_NO_PATH;
                end else begin
                    res_status_next = gass_pkg::ST_GOAL;
                end
            end
            gass_pkg::S_SCAN: begin
                rv_next  = 1'b1;
                idx_next = idx_reg + IW'(1);
                if (ix_reg == X_MAX) begin
                    ix_next = '0;
                    iz_next = iz_reg + CW'(1);
                end else begin
                    ix_next = ix_reg + CW'(1);
                end
            end
            gass_pkg::S_CLOSE: begin
                nd_next = '0;
                if (!bv_reg) begin
                    phase_next      = gass_pkg::PH_NOPATH;
                    res_status_next = gass_pkg::ST_NO_PATH;
                end else if (bx_reg == gx_reg && bz_reg == gz_reg) begin
                    phase_next      = gass_pkg::PH_FOUND;
                    cx_next         = gx_reg;
                    cz_next         = gz_reg;
                    res_status_next = gass_pkg::ST_GOAL;
                end else begin
                    res_status_next = gass_pkg::ST_SEARCHING;
                end
            end
            gass_pkg::S_NB_RD: begin
                nx_next   = ncx;
                nz_next   = ncz;
                nidx_next = index_of(ncx, ncz);
                if (n_off) begin
                    nd_next = nd_reg + 3'd1;
                end
            end
            gass_pkg::S_NB_WR: begin
                nd_next = nd_reg + 3'd1;
                if (ram_rdata.mark != gass_pkg::MK_OPEN &&
                    ram_rdata.mark != gass_pkg::MK_CLOSED) begin
                    stamp_next = stamp_reg + gass_pkg::STAMP_W'(1);
                end
            end
            gass_pkg::S_PATH_WR: begin
                // Step back along the stored move, clamped to the grid.
                res_status_next = gass_pkg::ST_PATH_CELL;
                res_px_next     = 4'(cx_reg);
                res_pz_next     = 4'(cz_reg);
                if (pm.xp) begin
                    cx_next = (cx_reg == '0) ? '0 : cx_reg - CW'(1);
                end else if (pm.xn) begin
                    cx_next = (cx_reg == X_MAX) ? X_MAX : cx_reg + CW'(1);
                end
                if (pm.zp) begin
                    cz_next = (cz_reg == '0) ? '0 : cz_reg - CW'(1);
                end else if (pm.zn) begin
                    cz_next = (cz_reg == X_MAX) ? X_MAX : cz_reg + CW'(1);
                end
            end
            default: begin
                rv_next = 1'b0;
            end
        endcase
    end

    // Output register.
    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_px_next     = m_px_reg;
        m_pz_next     = m_pz_reg;
        m_last_next   = m_last_reg;
        if (state_reg == gass_pkg::S_RESULT && out_free) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_px_next     = res_px_reg;
            m_pz_next     = res_pz_reg;
            m_last_next   = res_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gass_pkg::S_IDLE;
            phase_reg   <= gass_pkg::PH_IDLE;
            m_valid_reg <= 1'b0;
            stamp_reg   <= '0;
            sx_reg <= '0;  sz_reg <= '0;  gx_reg <= '0;  gz_reg <= '0;
            cx_reg <= '0;  cz_reg <= '0;
            rv_reg <= 1'b0;
            bv_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            stamp_reg   <= stamp_next;
            sx_reg <= sx_next;  sz_reg <= sz_next;  gx_reg <= gx_next;  gz_reg <= gz_next;
            cx_reg <= cx_next;  cz_reg <= cz_next;
            rv_reg <= rv_next;
            bv_reg <= bv_next;
        end
    end

    always_ff @(posedge aclk) begin
        ix_reg <= ix_next;  iz_reg <= iz_next;  idx_reg <= idx_next;
        rx_reg <= rx_next;  rz_reg <= rz_next;  ridx_reg <= ridx_next;
        bf_reg <= bf_next;  bg_reg <= bg_next;  bs_reg <= bs_next;
        bidx_reg <= bidx_next;  bx_reg <= bx_next;  bz_reg <= bz_next;  bd_reg <= bd_next;
        nd_reg <= nd_next;  nx_reg <= nx_next;  nz_reg <= nz_next;  nidx_reg <= nidx_next;
        res_status_reg <= res_status_next;
        res_px_reg     <= res_px_next;
        res_pz_reg     <= res_pz_next;
        res_last_reg   <= res_last_next;
        m_status_reg   <= m_status_next;
        m_px_reg       <= m_px_next;
        m_pz_reg       <= m_pz_next;
        m_last_reg     <= m_last_next;
    end

    assign s_ready  = (state_reg == gass_pkg::S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_path_x = m_px_reg;
    assign m_path_z = m_pz_reg;
    assign m_last   = m_last_reg;

`ifndef SYNTHESIS
    // The scan only reads the cell memory.
    a_scan_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gass_pkg::S_SCAN || state_reg == gass_pkg::S_SCAN_END) |-> !ram_we)
        else $error("cell memory written during scan");

    // A neighbour is only visited after an open cell was chosen.
    a_nb_has_best: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gass_pkg::S_NB_RD || state_reg == gass_pkg::S_NB_WR) |-> bv_reg)
        else $error("neighbour walk without a best cell");

    // Reaching the goal points the path cursor at the goal.
    a_found_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == gass_pkg::PH_FOUND && $past(phase_reg) != gass_pkg::PH_FOUND)
        |-> (cx_reg == gx_reg && cz_reg == gz_reg))
        else $error("path cursor not at goal when goal found");

    // A result is only loaded into a free output register.
    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gass_pkg::S_RESULT && m_valid_reg && !m_ready)
        |=> (state_reg == gass_pkg::S_RESULT))
        else $error("result dropped while output busy");
`endif

endmodule
